// ===== rtl/tcw_pkg.sv =====
// Shared constants, types and byte codes for the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TERMINALS = 4;

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int DEPTH    = TERMINALS * CELLS;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int TERM_W   = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
    localparam int ROWSEL_W = $clog2(TERMINALS * ROWS);
    localparam int ADDR_W   = $clog2(DEPTH);

    localparam logic [ROW_W:0]      ROWS_EXT = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]    ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]    COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROWSEL_W-1:0] ROWSEL_LAST = ROWSEL_W'(TERMINALS * ROWS - 1);

    // Port field widths
    localparam int CMD_W     = 2;
    localparam int TERMIN_W  = 3;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 11;
    localparam int CELL_W    = 16;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 32;

    // Row of a cell index: multiply by a rounded-up reciprocal of COLUMNS and shift,
    // exact for every IDX_W-bit index
    localparam int DIV_SHIFT = IDX_W + COL_W;
    localparam int DIV_RECIP = (2 ** DIV_SHIFT + COLUMNS - 1) / COLUMNS;

    // Cell contents
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [7:0]        TEXT_ATTR  = 8'h07;
    localparam logic [3:0]        TAB_STOP   = 4'd8;

    // Byte codes
    localparam logic [7:0] BYTE_BS    = 8'd8;
    localparam logic [7:0] BYTE_TAB   = 8'd9;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_FIRST = 8'd32;
    localparam logic [7:0] CHAR_END   = 8'd127;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_SELECT = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_PLACE,
        ST_WRITE,
        ST_SCROLL,
        ST_DIV,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/tcw_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: command sequencer around the screen cell RAM.
//
//  channel | dir | handshake                  | word
//  --------+-----+----------------------------+--------------------------------------
//  s       | in  | i_s_tvalid / o_s_tready    | tdata: terminal, byte, cell index;
//          |     |                            | tuser: command; tlast: last byte
//  m       | out | o_m_tvalid / i_m_tready    | tdata: status, refresh, cell, cursor,
//          |     |                            | active terminal
//
// One word at a time. Select, CR and ignored bytes go from decode to the result step;
// a stored character or a backspace adds one place and one write step, a tab one pair
// per space (up to 8 spaces). Any scroll blanks one row through the single RAM port; the
// screen rows form a ring per terminal, so no cells are moved.
// A read takes its row from a reciprocal multiply of cell_index; an index out of range
// skips the RAM and returns a zero cell. After reset the RAM is swept to blank cells,
// with o_s_tready low. A stalled m side holds the result; the next word is accepted
// meanwhile and waits in the last step until the result register frees.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [2:0] terminal, [10:3] byte_value, [21:11] cell_index, [23:22] zero
    input  wire logic [23:0] i_s_tdata,
    // [1:0] command
    input  wire logic [1:0]  i_s_tuser,
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [0] status, [1] refresh, [17:2] cell_value, [28:18] cursor_position,
    // [30:29] active_terminal, [31] zero
    output logic      [31:0] o_m_tdata
);

    function automatic logic [tcw_pkg::ROW_W-1:0] f_phys(
        input logic [tcw_pkg::ROW_W-1:0] lrow,
        input logic [tcw_pkg::ROW_W-1:0] top
    );
        logic [tcw_pkg::ROW_W:0] s;
        s = {1'b0, lrow} + {1'b0, top};
        if (s >= tcw_pkg::ROWS_EXT) begin
            s = s - tcw_pkg::ROWS_EXT;
        end
        return s[tcw_pkg::ROW_W-1:0];
    endfunction

    function automatic logic [tcw_pkg::ROWSEL_W-1:0] f_rowsel(
        input logic [tcw_pkg::TERM_W-1:0] term,
        input logic [tcw_pkg::ROW_W-1:0]  prow
    );
        return tcw_pkg::ROWSEL_W'(tcw_pkg::ROWSEL_W'(term) * tcw_pkg::ROWSEL_W'(tcw_pkg::ROWS)
                                  + tcw_pkg::ROWSEL_W'(prow));
    endfunction

    tcw_pkg::t_state r_state, n_state;

    // Word being processed
    tcw_pkg::t_cmd                r_cmd, n_cmd;
    logic [tcw_pkg::TERM_W-1:0]   r_term, n_term;
    logic                         r_bad, n_bad;
    logic [7:0]                   r_byte, n_byte;
    logic                         r_last, n_last;
    logic [tcw_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic                         r_hit, n_hit;
    logic [3:0]                   r_left, n_left;
    logic [tcw_pkg::CELL_W-1:0]   r_wdata, n_wdata;
    logic                         r_adv, n_adv;
    logic [tcw_pkg::ROW_W-1:0]    r_lrow, n_lrow;

    // RAM row/column pointer, also the clearing sweep counter
    logic [tcw_pkg::ROWSEL_W-1:0] r_rowsel, n_rowsel;
    logic [tcw_pkg::COL_W-1:0]    r_col, n_col;

    // Per-terminal cursor and ring top row
    logic [tcw_pkg::ROW_W-1:0]    r_cur_row [tcw_pkg::TERMINALS];
    logic [tcw_pkg::ROW_W-1:0]    n_cur_row [tcw_pkg::TERMINALS];
    logic [tcw_pkg::COL_W-1:0]    r_cur_col [tcw_pkg::TERMINALS];
    logic [tcw_pkg::COL_W-1:0]    n_cur_col [tcw_pkg::TERMINALS];
    logic [tcw_pkg::ROW_W-1:0]    r_top [tcw_pkg::TERMINALS];
    logic [tcw_pkg::ROW_W-1:0]    n_top [tcw_pkg::TERMINALS];
    logic [tcw_pkg::TERM_W-1:0]   r_active, n_active;

    // Result register
    logic                         r_oval, n_oval;
    logic                         r_status, n_status;
    logic                         r_refresh, n_refresh;
    logic [tcw_pkg::CELL_W-1:0]   r_value, n_value;
    logic [10:0]                  r_curpos, n_curpos;
    logic [1:0]                   r_act, n_act;

    // RAM port
    logic                         ram_we;
    logic                         ram_re;
    logic [tcw_pkg::ADDR_W-1:0]   ram_addr;
    logic [tcw_pkg::CELL_W-1:0]   ram_wdata;
    logic [tcw_pkg::CELL_W-1:0]   ram_rdata;

    // Helpers
    logic [tcw_pkg::ROW_W-1:0]    cur_row;
    logic [tcw_pkg::COL_W-1:0]    cur_col;
    logic [tcw_pkg::ROW_W-1:0]    cur_top;
    logic [15:0]                  cur_lin;
    logic [15:0]                  act_lin;
    logic [2:0]                   act_ext;
    logic                         row_last;
    logic                         col_last;
    logic                         sweep_col_last;
    logic                         clear_last;
    logic [31:0]                  div_prod;
    logic                         idx_ok;
    logic                         out_free;
    logic                         is_cr, is_lf, is_bs, is_tab, is_print;

    assign cur_row  = r_cur_row[r_term];
    assign cur_col  = r_cur_col[r_term];
    assign cur_top  = r_top[r_term];
    assign cur_lin  = 16'(16'(cur_row) * 16'(tcw_pkg::COLUMNS) + 16'(cur_col));
    assign act_lin  = 16'(16'(r_cur_row[r_active]) * 16'(tcw_pkg::COLUMNS)
                          + 16'(r_cur_col[r_active]));
    assign act_ext  = 3'(r_active);
    assign row_last = (cur_row == tcw_pkg::ROW_LAST);
    assign col_last = (cur_col == tcw_pkg::COL_LAST);
    assign sweep_col_last = (r_col == tcw_pkg::COL_LAST);
    assign clear_last     = sweep_col_last && (r_rowsel == tcw_pkg::ROWSEL_LAST);
    assign div_prod = 32'(r_idx) * 32'(tcw_pkg::DIV_RECIP);
    assign idx_ok   = (16'(r_idx) < 16'(tcw_pkg::CELLS));
    assign out_free = !r_oval || i_m_tready;

    assign is_cr    = (r_byte == tcw_pkg::BYTE_CR);
    assign is_lf    = (r_byte == tcw_pkg::BYTE_LF);
    assign is_bs    = (r_byte == tcw_pkg::BYTE_BS);
    assign is_tab   = (r_byte == tcw_pkg::BYTE_TAB);
    assign is_print = (r_byte >= tcw_pkg::CHAR_FIRST) && (r_byte < tcw_pkg::CHAR_END);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::ST_CLEAR: begin
                if (clear_last) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = tcw_pkg::ST_DECODE;
                end
            end
            tcw_pkg::ST_DECODE: begin
                unique case (r_cmd)
                    tcw_pkg::CMD_WRITE: begin
                        priority if (r_bad) begin
                            n_state = tcw_pkg::ST_DONE;
                        end else if (is_lf && row_last) begin
                            n_state = tcw_pkg::ST_SCROLL;
                        end else if (is_bs || is_tab || is_print) begin
                            n_state = tcw_pkg::ST_PLACE;
                        end else begin
                            n_state = tcw_pkg::ST_DONE;
                        end
                    end
                    tcw_pkg::CMD_READ: begin
                        n_state = idx_ok ? tcw_pkg::ST_DIV : tcw_pkg::ST_DONE;
                    end
                    default: begin
                        n_state = tcw_pkg::ST_DONE;
                    end
                endcase
            end
            tcw_pkg::ST_PLACE: begin
                n_state = tcw_pkg::ST_WRITE;
            end
            tcw_pkg::ST_WRITE: begin
                priority if (r_adv && col_last && row_last) begin
                    n_state = tcw_pkg::ST_SCROLL;
                end else if (r_left != 4'd1) begin
                    n_state = tcw_pkg::ST_PLACE;
                end else begin
                    n_state = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_SCROLL: begin
                if (sweep_col_last) begin
                    n_state = (r_left != 4'd0) ? tcw_pkg::ST_PLACE : tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DIV: begin
                n_state = tcw_pkg::ST_READ;
            end
            tcw_pkg::ST_READ: begin
                n_state = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_cmd     = r_cmd;
        n_term    = r_term;
        n_bad     = r_bad;
        n_byte    = r_byte;
        n_last    = r_last;
        n_idx     = r_idx;
        n_hit     = r_hit;
        n_left    = r_left;
        n_wdata   = r_wdata;
        n_adv     = r_adv;
        n_lrow    = r_lrow;
        n_rowsel  = r_rowsel;
        n_col     = r_col;
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        n_top     = r_top;
        n_active  = r_active;
        n_status  = r_status;
        n_refresh = r_refresh;
        n_value   = r_value;
        n_curpos  = r_curpos;
        n_act     = r_act;
        n_oval    = r_oval && !i_m_tready;

        unique case (r_state)
            tcw_pkg::ST_CLEAR: begin
                n_col = sweep_col_last ? '0 : r_col + 1'b1;
                if (sweep_col_last) begin
                    n_rowsel = r_rowsel + 1'b1;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd  = tcw_pkg::t_cmd'(i_s_tuser);
                    n_term = tcw_pkg::TERM_W'(i_s_tdata[2:0]);
                    n_bad  = (32'(i_s_tdata[2:0]) >= 32'(tcw_pkg::TERMINALS));
                    n_byte = i_s_tdata[10:3];
                    n_idx  = i_s_tdata[21:11];
                    n_last = i_s_tlast;
                end
            end
            tcw_pkg::ST_DECODE: begin
                unique case (r_cmd)
                    tcw_pkg::CMD_WRITE: begin
                        if (!r_bad) begin
                            priority if (is_cr) begin
                                n_cur_col[r_term] = '0;
                            end else if (is_lf) begin
                                n_cur_col[r_term] = '0;
                                n_left = 4'd0;
                                if (row_last) begin
                                    // scroll: old top row becomes the blank bottom row
                                    n_rowsel = f_rowsel(r_term, cur_top);
                                    n_col    = '0;
                                    n_top[r_term] = (cur_top == tcw_pkg::ROW_LAST) ?
                                                    '0 : cur_top + 1'b1;
                                    n_cur_row[r_term] = tcw_pkg::ROW_LAST;
                                end else begin
                                    n_cur_row[r_term] = cur_row + 1'b1;
                                end
                            end else if (is_bs) begin
                                if (cur_col != '0) begin
                                    n_cur_col[r_term] = cur_col - 1'b1;
                                end else if (cur_row != '0) begin
                                    n_cur_row[r_term] = cur_row - 1'b1;
                                    n_cur_col[r_term] = tcw_pkg::COL_LAST;
                                end
                                n_wdata = tcw_pkg::BLANK_CELL;
                                n_adv   = 1'b0;
                                n_left  = 4'd1;
                            end else if (is_tab) begin
                                n_wdata = {tcw_pkg::TEXT_ATTR, tcw_pkg::CHAR_SPACE};
                                n_adv   = 1'b1;
                                n_left  = tcw_pkg::TAB_STOP - {1'b0, cur_lin[2:0]};
                            end else if (is_print) begin
                                n_wdata = {tcw_pkg::TEXT_ATTR, r_byte};
                                n_adv   = 1'b1;
                                n_left  = 4'd1;
                            end
                        end
                    end
                    tcw_pkg::CMD_SELECT: begin
                        if (!r_bad) begin
                            n_active = r_term;
                        end
                    end
                    tcw_pkg::CMD_READ: begin
                        n_hit  = idx_ok;
                        n_lrow = tcw_pkg::ROW_W'(div_prod >> tcw_pkg::DIV_SHIFT);
                    end
                    default: begin
                        n_hit = 1'b0;
                    end
                endcase
            end
            tcw_pkg::ST_PLACE: begin
                n_rowsel = f_rowsel(r_term, f_phys(cur_row, cur_top));
                n_col    = cur_col;
            end
            tcw_pkg::ST_WRITE: begin
                n_left = r_left - 1'b1;
                if (r_adv) begin
                    if (col_last) begin
                        n_cur_col[r_term] = '0;
                        if (row_last) begin
                            n_rowsel = f_rowsel(r_term, cur_top);
                            n_col    = '0;
                            n_top[r_term] = (cur_top == tcw_pkg::ROW_LAST) ?
                                            '0 : cur_top + 1'b1;
                        end else begin
                            n_cur_row[r_term] = cur_row + 1'b1;
                        end
                    end else begin
                        n_cur_col[r_term] = cur_col + 1'b1;
                    end
                end
            end
            tcw_pkg::ST_SCROLL: begin
                n_col = r_col + 1'b1;
            end
            tcw_pkg::ST_DIV: begin
                n_rowsel = f_rowsel(r_active, f_phys(r_lrow, r_top[r_active]));
                n_col    = tcw_pkg::COL_W'(16'(r_idx) -
                                           16'(r_lrow) * 16'(tcw_pkg::COLUMNS));
            end
            tcw_pkg::ST_READ: begin
                n_col = r_col;
            end
            tcw_pkg::ST_DONE: begin
                if (out_free) begin
                    n_oval    = 1'b1;
                    n_status  = r_bad && (r_cmd == tcw_pkg::CMD_WRITE ||
                                          r_cmd == tcw_pkg::CMD_SELECT);
                    n_refresh = !r_bad && ((r_cmd == tcw_pkg::CMD_SELECT) ||
                                           (r_cmd == tcw_pkg::CMD_WRITE && r_last &&
                                            r_term == r_active));
                    n_value   = (r_cmd == tcw_pkg::CMD_READ && r_hit) ? ram_rdata : '0;
                    n_curpos  = act_lin[10:0];
                    n_act     = act_ext[1:0];
                end
            end
            default: begin
                n_oval = r_oval && !i_m_tready;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tcw_pkg::ST_CLEAR;
            r_rowsel <= '0;
            r_col    <= '0;
            r_active <= '0;
            r_oval   <= 1'b0;
            for (int t = 0; t < tcw_pkg::TERMINALS; t++) begin
                r_cur_row[t] <= '0;
                r_cur_col[t] <= '0;
                r_top[t]     <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_rowsel  <= n_rowsel;
            r_col     <= n_col;
            r_active  <= n_active;
            r_oval    <= n_oval;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_top     <= n_top;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_term    <= n_term;
        r_bad     <= n_bad;
        r_byte    <= n_byte;
        r_last    <= n_last;
        r_idx     <= n_idx;
        r_hit     <= n_hit;
        r_left    <= n_left;
        r_wdata   <= n_wdata;
        r_adv     <= n_adv;
        r_lrow    <= n_lrow;
        r_status  <= n_status;
        r_refresh <= n_refresh;
        r_value   <= n_value;
        r_curpos  <= n_curpos;
        r_act     <= n_act;
    end

    assign ram_we = (r_state == tcw_pkg::ST_CLEAR) || (r_state == tcw_pkg::ST_SCROLL) ||
                    (r_state == tcw_pkg::ST_WRITE);
    assign ram_re = (r_state == tcw_pkg::ST_READ);
    assign ram_wdata = (r_state == tcw_pkg::ST_WRITE) ? r_wdata : tcw_pkg::BLANK_CELL;
    assign ram_addr = tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(r_rowsel) *
                                       tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS) +
                                       tcw_pkg::ADDR_W'(r_col));

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == tcw_pkg::ST_IDLE);
    assign o_m_tvalid = r_oval;
    assign o_m_tdata  = {1'b0, r_act, r_curpos, r_value, r_refresh, r_status};

    // Checks
    a_ram_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("RAM read and write in the same cycle");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == tcw_pkg::ST_DONE))
        else $error("result raised outside the final step");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::ST_IDLE) |->
            (r_cur_row[r_active] < tcw_pkg::ROWS) && (r_cur_col[r_active] < tcw_pkg::COLUMNS))
        else $error("active cursor outside the screen");

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top[r_active] < tcw_pkg::ROWS)
        else $error("ring top row out of range");

endmodule

`default_nettype wire

// ===== dv/text_console_writer_test.sv =====
// Self-checking bench for the text console writer: directed and random console commands.
`timescale 1ns / 1ps

module text_console_writer_test;
    import tcw_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int DIRECTED_COUNT = 25;
    localparam int ITEM_COUNT     = 1150;
    localparam int QUIET_LIMIT    = 40000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int MAX_LINES      = 40;
    localparam int IDX_TOP        = 2047;

    typedef struct packed {
        logic              status;
        logic              refresh;
        logic [CELL_W-1:0] cell_value;
        logic [IDX_W-1:0]  cursor;
        logic [1:0]        active;
    } console_reply_t;

    class console_scoreboard;
        logic [CELL_W-1:0] screen [DEPTH];
        int unsigned       cursor_at [TERMINALS];
        int unsigned       active_term;
        console_reply_t    pending_replies [$];
        int                mismatches;

        function new();
            foreach (screen[i]) screen[i] = BLANK_CELL;
            foreach (cursor_at[i]) cursor_at[i] = 0;
            active_term = 0;
            mismatches = 0;
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= MAX_LINES)
                $display("mismatch %s: expected 'h%0h, got 'h%0h at %0t", what, want, got, $time);
        endfunction

        // shift the whole screen up one row and blank the bottom row
        function void scroll_up(int unsigned t);
            int unsigned base;
            base = t * CELLS;
            for (int unsigned i = 0; i + COLUMNS < CELLS; i++)
                screen[base + i] = screen[base + i + COLUMNS];
            for (int unsigned i = CELLS - COLUMNS; i < CELLS; i++)
                screen[base + i] = BLANK_CELL;
            cursor_at[t] = CELLS - COLUMNS;
        endfunction

        function void place_char(int unsigned t, logic [7:0] ch);
            if (cursor_at[t] >= CELLS) scroll_up(t);
            screen[t * CELLS + cursor_at[t]] = {TEXT_ATTR, ch};
            cursor_at[t]++;
            if (cursor_at[t] >= CELLS) scroll_up(t);
        endfunction

        function void feed_byte(int unsigned t, logic [7:0] b);
            int unsigned c;
            int unsigned n;
            c = cursor_at[t];
            if (b == BYTE_CR) begin
                cursor_at[t] = c - c % COLUMNS;
            end else if (b == BYTE_LF) begin
                cursor_at[t] = c + (COLUMNS - c % COLUMNS);
            end else if (b == BYTE_BS) begin
                if (c != 0) c--;
                cursor_at[t] = c;
                if (c < CELLS) screen[t * CELLS + c] = BLANK_CELL;
            end else if (b == BYTE_TAB) begin
                n = TAB_STOP - c % TAB_STOP;
                repeat (n) place_char(t, CHAR_SPACE);
                return;
            end else if (b >= CHAR_FIRST && b < CHAR_END) begin
                place_char(t, b);
                return;
            end
            if (cursor_at[t] >= CELLS) scroll_up(t);
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [TERMIN_W-1:0] term,
                                   logic [BYTE_W-1:0] b, logic last, logic [IDX_W-1:0] idx);
            console_reply_t r;
            r = '0;
            case (cmd)
                CMD_WRITE: begin
                    if (term >= TERMINALS) begin
                        r.status = 1'b1;
                    end else begin
                        feed_byte(term, b);
                        r.refresh = last && (term == active_term);
                    end
                end
                CMD_SELECT: begin
                    if (term >= TERMINALS) begin
                        r.status = 1'b1;
                    end else begin
                        active_term = term;
                        r.refresh = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (idx < CELLS) r.cell_value = screen[active_term * CELLS + idx];
                end
                default: ;
            endcase
            r.cursor = IDX_W'(cursor_at[active_term]);
            r.active = 2'(active_term);
            pending_replies.push_back(r);
        endfunction

        function void check_word(logic [M_DATA_W-1:0] w);
            console_reply_t want;
            if (pending_replies.size() == 0) begin
                report("result with nothing pending", 0, w);
                return;
            end
            want = pending_replies.pop_front();
            if (w[0] !== want.status) report("status", want.status, w[0]);
            if (w[1] !== want.refresh) report("refresh", want.refresh, w[1]);
            if (w[17:2] !== want.cell_value) report("cell_value", want.cell_value, w[17:2]);
            if (w[28:18] !== want.cursor) report("cursor_position", want.cursor, w[28:18]);
            if (w[30:29] !== want.active) report("active_terminal", want.active, w[30:29]);
        endfunction
    endclass

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]    s_tuser  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tready = 1'b0;
    wire                 o_s_tready;
    wire                 o_m_tvalid;
    wire [M_DATA_W-1:0]  o_m_tdata;

    console_scoreboard sb;
    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int items_sent      = 0;
    int quiet_cycles    = 0;

    text_console_writer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) sb.check_word(o_m_tdata);
    end

    // the clearing sweep after reset keeps the input side closed until every cell is blank
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("[text_console_writer] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [TERMIN_W-1:0] term,
                             input logic [BYTE_W-1:0] b, input logic last,
                             input logic [IDX_W-1:0] idx);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, idx, b, term};
        s_tuser  <= cmd;
        s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_command(cmd, term, b, last, idx);
        items_sent++;
    endtask

    initial begin
        int unsigned      pick;
        int unsigned      span;
        logic [TERMIN_W-1:0] term;
        logic [BYTE_W-1:0]   b;
        logic             broken;

        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: byte classes, error terminals, refresh rules, read bounds
        send_word(CMD_READ,   0, 0,          0, 0);
        send_word(CMD_WRITE,  0, "A",        1, 0);
        send_word(CMD_WRITE,  0, 8'd126,     0, 0);
        send_word(CMD_WRITE,  0, CHAR_SPACE, 0, 0);
        send_word(CMD_WRITE,  0, BYTE_TAB,   1, 0);
        send_word(CMD_WRITE,  0, BYTE_BS,    0, 0);
        send_word(CMD_WRITE,  0, BYTE_CR,    0, 0);
        send_word(CMD_WRITE,  0, BYTE_BS,    0, 0);
        send_word(CMD_WRITE,  0, BYTE_LF,    0, 0);
        send_word(CMD_WRITE,  0, CHAR_END,   0, 0);
        send_word(CMD_WRITE,  0, 8'd255,     1, 0);
        send_word(CMD_WRITE,  0, 8'd0,       0, 0);
        send_word(CMD_WRITE,  0, 8'd31,      0, 0);
        send_word(CMD_WRITE,  5, "x",        1, 0);
        send_word(CMD_SELECT, 7, 0,          0, 0);
        send_word(CMD_SELECT, 3, 0,          0, 0);
        send_word(CMD_WRITE,  3, "Z",        1, 0);
        send_word(CMD_WRITE,  1, "q",        1, 0);
        send_word(CMD_READ,   0, 0,          0, 0);
        send_word(CMD_READ,   0, 0,          0, CELLS - 1);
        send_word(CMD_READ,   0, 0,          0, CELLS);
        send_word(CMD_READ,   0, 0,          0, IDX_TOP);
        send_word(CMD_UNUSED, 7, 8'd255,     1, IDX_TOP);
        send_word(CMD_SELECT, 0, 0,          0, 0);
        send_word(CMD_READ,   4, 8'd255,     1, 3);

        while (items_sent < ITEM_COUNT) begin
            case ((items_sent - DIRECTED_COUNT) * 4 / (ITEM_COUNT - DIRECTED_COUNT))
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 49; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 49; end
                default: begin sender_idle_pct = 19; sink_stall_pct = 19; end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                // write burst to one terminal, mostly the active one so scrolls show up
                if ($urandom_range(0, 19) == 0) term = $urandom_range(TERMINALS, 7);
                else if ($urandom_range(0, 9) < 7) term = sb.active_term;
                else term = $urandom_range(0, TERMINALS - 1);
                span = $urandom_range(1, 12);
                broken = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < span; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45) b = $urandom_range(CHAR_FIRST, CHAR_END - 1);
                    else if (pick < 65) b = BYTE_LF;
                    else if (pick < 75) b = BYTE_TAB;
                    else if (pick < 80) b = BYTE_CR;
                    else if (pick < 86) b = BYTE_BS;
                    else if (pick < 93) b = $urandom_range(0, 255);
                    else b = $urandom_range(0, CHAR_FIRST - 1);
                    send_word(CMD_WRITE, term, b,
                              broken ? 1'($urandom_range(0, 1)) : (k == span - 1),
                              $urandom_range(0, IDX_TOP));
                end
            end else if (pick < 82) begin
                term = ($urandom_range(0, 9) < 8) ? $urandom_range(0, TERMINALS - 1)
                                                  : $urandom_range(TERMINALS, 7);
                send_word(CMD_SELECT, term, $urandom_range(0, 255), $urandom_range(0, 1),
                          $urandom_range(0, IDX_TOP));
            end else if (pick < 97) begin
                send_word(CMD_READ, $urandom_range(0, 7), $urandom_range(0, 255),
                          $urandom_range(0, 1),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(CELLS, IDX_TOP)
                                                      : $urandom_range(0, CELLS - 1));
            end else begin
                send_word(CMD_UNUSED, $urandom_range(0, 7), $urandom_range(0, 255),
                          $urandom_range(0, 1), $urandom_range(0, IDX_TOP));
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("[text_console_writer] OK");
        end else begin
            $display("[text_console_writer] ERROR");
        end
        $finish;
    end

endmodule
